// File: src/c_string_literal_escaper_core_macros.svh
// Assertion macros for the checker file of the escaper core.
`ifndef C_STRING_LITERAL_ESCAPER_CORE_MACROS_SVH
`define C_STRING_LITERAL_ESCAPER_CORE_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define CSLESC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("escaper check failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define CSLESC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("escaper check failed");

`endif

// File: src/cslesc_pkg.sv
// Types, character codes and helpers shared by the escaper core modules.
`default_nettype none
package cslesc_pkg;

    typedef enum logic [1:0] {
        MODE_NEVER  = 2'd0,
        MODE_STD    = 2'd1,
        MODE_STRICT = 2'd2,
        MODE_NUMBER = 2'd3
    } mode_t;

    // How the back end expands one queued item
    typedef enum logic [1:0] {
        KIND_RAW  = 2'd0,
        KIND_PAIR = 2'd1,
        KIND_HEX  = 2'd2,
        KIND_EOL  = 2'd3
    } kind_t;

    typedef struct packed {
        logic       open;
        kind_t      kind;
        logic [7:0] data;
    } rec_t;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_APOS    = 8'h27;
    localparam logic [7:0] CH_BSLASH  = 8'h5c;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] CH_NL      = 8'h0a;
    localparam logic [7:0] CH_DEL     = 8'h7f;
    localparam logic [7:0] CTRL_LAST  = 8'h1f;
    localparam logic [7:0] HEX_ALPHA  = 8'h57;

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] wide;
        wide = {4'h0, n};
        hex_digit = (n < 4'd10) ? (CH_ZERO + wide) : (HEX_ALPHA + wide);
    endfunction

    function automatic logic [2:0] kind_len(input kind_t k);
        case (k)
            KIND_RAW:  kind_len = 3'd1;
            KIND_PAIR: kind_len = 3'd2;
            KIND_HEX:  kind_len = 3'd4;
            KIND_EOL:  kind_len = 3'd2;
            default:   kind_len = 3'd1;
        endcase
    endfunction

endpackage
`default_nettype wire

// File: src/c_string_literal_escaper_core.sv
// Top level of the C string literal escaper: front end, item queue, back end.
//
// Input channel (s_): one beat per text byte in s_tdata, or an end-of-line
// beat with s_tlast high (s_tdata ignored). Output channel (m_): one literal
// byte per beat in m_tdata; m_tlast marks the final byte of each input beat.
// The first beat of a line adds an opening quote; end-of-line gives a quote
// and a newline. The configuration channel (cfg_) sets the escape mode:
// 0 none, 1 standard, 2 strict with high bytes, 3 every byte as \xHH.
// Write it only while the block is idle; cfg_ready is always high.
// The first output byte of a beat goes through the queue, then the output
// register. The back end sends one byte per cycle while the receiver is
// ready and the queue holds an item. An input beat gives 1 to 5 output bytes
// (4 or 5 for a hex escape), and the output channel sets the sustained rate.
// Reset clears the open-line flag, empties the queue, drops m_tvalid and
// selects standard mode. When the receiver stalls, the output register holds
// its byte, the two-entry queue fills, and then s_tready falls.
`default_nettype none
module c_string_literal_escaper_core (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] char_in
    input  wire logic       s_tlast,   // end_line
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_char
    output logic            m_tlast,   // last
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_data   // [1:0] escape_mode
);

    cslesc_pkg::rec_t push_rec, head_rec;
    logic             push, full, pop, head_valid;

    cslesc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (full),
        .q_push    (push),
        .q_rec     (push_rec)
    );

    cslesc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_rec   (push_rec),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    cslesc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
`default_nettype wire

// File: src/cslesc_front.sv
// Front end: takes input beats, tracks the open line and classifies each byte.
`default_nettype none
module cslesc_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,   // [7:0] char_in
    input  wire logic             s_tlast,   // end_line
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [1:0]       cfg_data,  // [1:0] escape_mode
    input  wire logic             q_full,
    output logic                  q_push,
    output cslesc_pkg::rec_t      q_rec
);

    cslesc_pkg::mode_t mode_reg, mode_next;
    logic              line_open_reg, line_open_next;
    cslesc_pkg::kind_t text_kind;
    logic [7:0]        text_data;
    logic              is_ctrl;

    assign s_tready  = !q_full;
    assign cfg_ready = 1'b1;
    assign q_push    = s_tvalid && !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= cslesc_pkg::MODE_STD;
            line_open_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            line_open_reg <= line_open_next;
        end
    end

    always_comb begin
        mode_next      = cfg_valid ? cslesc_pkg::mode_t'(cfg_data) : mode_reg;
        line_open_next = q_push ? !s_tlast : line_open_reg;
    end

    always_comb begin
        is_ctrl   = (s_tdata <= cslesc_pkg::CTRL_LAST) || (s_tdata == cslesc_pkg::CH_DEL);
        text_kind = cslesc_pkg::KIND_RAW;
        text_data = s_tdata;
        case (mode_reg)
            cslesc_pkg::MODE_NEVER: begin
                text_kind = cslesc_pkg::KIND_RAW;
            end
            cslesc_pkg::MODE_NUMBER: begin
                text_kind = cslesc_pkg::KIND_HEX;
            end
            default: begin
                if (s_tdata inside {cslesc_pkg::CH_QUOTE, cslesc_pkg::CH_APOS,
                                    cslesc_pkg::CH_BSLASH}) begin
                    text_kind = cslesc_pkg::KIND_PAIR;
                end else if (s_tdata == 8'h00) begin
                    // NUL gets the short octal form
                    text_kind = cslesc_pkg::KIND_PAIR;
                    text_data = cslesc_pkg::CH_ZERO;
                end else if (is_ctrl ||
                             (mode_reg == cslesc_pkg::MODE_STRICT && s_tdata[7])) begin
                    text_kind = cslesc_pkg::KIND_HEX;
                end else begin
                    text_kind = cslesc_pkg::KIND_RAW;
                end
            end
        endcase
    end

    always_comb begin
        q_rec.open = !line_open_reg;
        q_rec.kind = s_tlast ? cslesc_pkg::KIND_EOL : text_kind;
        q_rec.data = text_data;
    end

endmodule
`default_nettype wire

// File: src/cslesc_queue.sv
// Short queue of classified items between the front and back ends.
`default_nettype none
module cslesc_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire cslesc_pkg::rec_t push_rec,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output cslesc_pkg::rec_t      head_rec
);

    localparam int DEPTH = cslesc_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    cslesc_pkg::rec_t mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_rec   = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_comb begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// File: src/cslesc_back.sv
// Back end: expands the head item into literal bytes, one per unstalled cycle.
`default_nettype none
module cslesc_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             head_valid,
    input  wire cslesc_pkg::rec_t head_rec,
    output logic                  pop,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [7:0]            m_tdata,   // [7:0] out_char
    output logic                  m_tlast    // last
);

    logic [2:0] step_reg, step_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;
    logic       m_tlast_reg, m_tlast_next;
    logic       load, final_step;
    logic [2:0] total, body_idx;
    logic [7:0] cur_byte;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        total      = {2'b00, head_rec.open} + cslesc_pkg::kind_len(head_rec.kind);
        body_idx   = step_reg - {2'b00, head_rec.open};
        final_step = (step_reg == total - 3'd1);
        load       = head_valid && (!m_tvalid_reg || m_tready);
        pop        = load && final_step;

        if (head_rec.open && step_reg == 3'd0) begin
            cur_byte = cslesc_pkg::CH_QUOTE;
        end else begin
            case (head_rec.kind)
                cslesc_pkg::KIND_RAW: begin
                    cur_byte = head_rec.data;
                end
                cslesc_pkg::KIND_PAIR: begin
                    cur_byte = (body_idx == 3'd0) ? cslesc_pkg::CH_BSLASH : head_rec.data;
                end
                cslesc_pkg::KIND_HEX: begin
                    case (body_idx)
                        3'd0:    cur_byte = cslesc_pkg::CH_BSLASH;
                        3'd1:    cur_byte = cslesc_pkg::CH_X;
                        3'd2:    cur_byte = cslesc_pkg::hex_digit(head_rec.data[7:4]);
                        default: cur_byte = cslesc_pkg::hex_digit(head_rec.data[3:0]);
                    endcase
                end
                default: begin
                    cur_byte = (body_idx == 3'd0) ? cslesc_pkg::CH_QUOTE : cslesc_pkg::CH_NL;
                end
            endcase
        end

        // advance through the item, restart on its final byte
        step_next     = load ? (final_step ? 3'd0 : step_reg + 3'd1) : step_reg;
        m_tvalid_next = load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
        m_tdata_next  = load ? cur_byte : m_tdata_reg;
        m_tlast_next  = load ? final_step : m_tlast_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= 3'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

endmodule
`default_nettype wire

// File: src/cslesc_checker.sv
// Port-level checker for the escaper core, bound to the top level.
`default_nettype none
`include "c_string_literal_escaper_core_macros.svh"
module cslesc_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic [7:0] s_tdata,
    input wire logic       s_tlast,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic       cfg_valid,
    input wire logic       cfg_ready,
    input wire logic [1:0] cfg_data
);

    logic [2:0] open_reg, open_next;
    logic       in_beat, done_beat;

    assign in_beat   = s_tvalid && s_tready;
    assign done_beat = m_tvalid && m_tready && m_tlast;

    // count input beats whose output is not yet fully delivered
    always_comb begin
        open_next = open_reg + 3'(in_beat) - 3'(done_beat);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= 3'd0;
        end else begin
            open_reg <= open_next;
        end
    end

    `CSLESC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `CSLESC_ASSERT_NOW(a_no_stray_out, m_tvalid, open_reg != 3'd0)
    `CSLESC_ASSERT_NOW(a_bounded_backlog, 1'b1, open_reg <= 3'd3)
    `CSLESC_ASSERT_NOW(a_reset_quiet, $past(!aresetn), !m_tvalid)

endmodule

bind c_string_literal_escaper_core cslesc_checker u_cslesc_checker (.*);
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the C string literal escaper core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } lit_beat_t;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] char_in
    logic       s_tlast;   // end_line
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] out_char
    logic       m_tlast;   // last
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_data;  // [1:0] escape_mode

    // Predictor state and the literal bytes still owed by the block
    cslesc_pkg::mode_t esc_mode;
    logic              line_is_open;
    lit_beat_t         lit_expect[$];
    int                fail_count;
    int unsigned       src_gap_max;
    int unsigned       sink_gap_max;
    lit_beat_t         lit_want;

    c_string_literal_escaper_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic logic [7:0] ascii_nibble(input logic [3:0] n);
        ascii_nibble = (n < 4'd10) ? (8'h30 + 8'(n)) : (8'h61 + 8'(n) - 8'd10);
    endfunction

    // Work out the literal bytes one accepted beat must produce.
    task automatic predict_literal(input logic [7:0] b, input logic eol);
        logic [7:0] lit[$];
        logic       as_hex;
        as_hex = 1'b0;
        if (!line_is_open) begin
            lit.push_back(cslesc_pkg::CH_QUOTE);
            line_is_open = 1'b1;
        end
        if (eol) begin
            lit.push_back(cslesc_pkg::CH_QUOTE);
            lit.push_back(cslesc_pkg::CH_NL);
            line_is_open = 1'b0;
        end else begin
            case (esc_mode)
                cslesc_pkg::MODE_NEVER: begin
                    lit.push_back(b);
                end
                cslesc_pkg::MODE_NUMBER: begin
                    as_hex = 1'b1;
                end
                default: begin
                    if (b == cslesc_pkg::CH_QUOTE || b == cslesc_pkg::CH_APOS ||
                        b == cslesc_pkg::CH_BSLASH) begin
                        lit.push_back(cslesc_pkg::CH_BSLASH);
                        lit.push_back(b);
                    end else if (b == 8'h00) begin
                        lit.push_back(cslesc_pkg::CH_BSLASH);
                        lit.push_back(cslesc_pkg::CH_ZERO);
                    end else if (b < 8'h20 || b == cslesc_pkg::CH_DEL ||
                                 (esc_mode == cslesc_pkg::MODE_STRICT && b[7])) begin
                        as_hex = 1'b1;
                    end else begin
                        lit.push_back(b);
                    end
                end
            endcase
            if (as_hex) begin
                lit.push_back(cslesc_pkg::CH_BSLASH);
                lit.push_back(cslesc_pkg::CH_X);
                lit.push_back(ascii_nibble(b[7:4]));
                lit.push_back(ascii_nibble(b[3:0]));
            end
        end
        foreach (lit[i])
            lit_expect.push_back('{out_char: lit[i], last: (i == lit.size() - 1)});
    endtask

    // Send one input beat after a random gap and record what it must yield.
    task automatic send_text(input logic [7:0] b, input logic eol);
        int unsigned gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap != 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tlast  <= 1'($urandom);
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eol;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        predict_literal(b, eol);
    endtask

    task automatic send_eol();
        send_text(8'($urandom), 1'b1);
    endtask

    // Drop the source and wait until every owed byte has come out.
    task automatic drain_literals();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (lit_expect.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_mode(input cslesc_pkg::mode_t m);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        esc_mode = m;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Bias toward bytes that the escape rules treat specially.
    function automatic logic [7:0] pick_text_byte();
        logic [7:0] specials[8];
        specials = '{cslesc_pkg::CH_QUOTE, cslesc_pkg::CH_APOS, cslesc_pkg::CH_BSLASH,
                     8'h00, cslesc_pkg::CH_DEL, cslesc_pkg::CTRL_LAST, 8'h80, 8'hff};
        if ($urandom_range(0, 2) == 0)
            pick_text_byte = specials[$urandom_range(0, 7)];
        else
            pick_text_byte = 8'($urandom_range(0, 255));
    endfunction

    // Standard mode straight out of reset: empty line, escapes, control and high bytes.
    task automatic test_default_mode_specials();
        logic [7:0] txt[11];
        txt = '{cslesc_pkg::CH_QUOTE, cslesc_pkg::CH_APOS, cslesc_pkg::CH_BSLASH,
                8'h00, 8'h01, cslesc_pkg::CTRL_LAST, 8'h20,
                cslesc_pkg::CH_DEL, 8'h80, 8'hff, 8'h7e};
        src_gap_max  = 3;
        sink_gap_max = 3;
        send_eol();
        foreach (txt[i])
            send_text(txt[i], 1'b0);
        send_eol();
        drain_literals();
    endtask

    // The other modes on the bytes where they differ most.
    task automatic test_mode_extremes();
        cslesc_pkg::mode_t modes[3];
        logic [7:0]        txt[4];
        modes = '{cslesc_pkg::MODE_NEVER, cslesc_pkg::MODE_STRICT, cslesc_pkg::MODE_NUMBER};
        txt   = '{8'h00, cslesc_pkg::CH_QUOTE, cslesc_pkg::CH_DEL, 8'hff};
        foreach (modes[m]) begin
            write_mode(modes[m]);
            foreach (txt[i])
                send_text(txt[i], 1'b0);
            send_eol();
            drain_literals();
        end
    endtask

    // Whole lines of random length and content under one mode.
    task automatic test_random_lines(input cslesc_pkg::mode_t m, input int n_beats,
                                     input int unsigned src_max, input int unsigned sink_max);
        int sent;
        int line_len;
        sent = 0;
        src_gap_max  = src_max;
        sink_gap_max = sink_max;
        write_mode(m);
        while (sent < n_beats) begin
            line_len = $urandom_range(0, 10);
            repeat (line_len) send_text(pick_text_byte(), 1'b0);
            send_eol();
            sent += line_len + 1;
        end
        drain_literals();
    endtask

    // Result sink: random stall before each beat.
    initial begin : sink_side
        int unsigned hold;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            hold = $urandom_range(0, sink_gap_max);
            if (hold != 0) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (hold - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (lit_expect.size() == 0) begin
                $error("unexpected beat: out_char %h last %b", m_tdata, m_tlast);
                fail_count++;
            end else begin
                lit_want = lit_expect.pop_front();
                if (m_tdata !== lit_want.out_char) begin
                    $error("out_char: expected %h, got %h", lit_want.out_char, m_tdata);
                    fail_count++;
                end
                if (m_tlast !== lit_want.last) begin
                    $error("last: expected %b, got %b", lit_want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'h00;
        s_tlast      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = 2'd0;
        esc_mode     = cslesc_pkg::MODE_STD;
        line_is_open = 1'b0;
        fail_count   = 0;
        src_gap_max  = 0;
        sink_gap_max = 0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        test_default_mode_specials();
        test_mode_extremes();
        test_random_lines(cslesc_pkg::MODE_NEVER, 40, 15, 15);
        test_random_lines(cslesc_pkg::MODE_NUMBER, 40, 15, 15);
        test_random_lines(cslesc_pkg::MODE_STD, 40, 0, 0);
        test_random_lines(cslesc_pkg::MODE_STRICT, 40, 15, 0);
        test_random_lines(cslesc_pkg::MODE_NUMBER, 35, 0, 15);
        repeat (2) test_random_lines(cslesc_pkg::mode_t'($urandom_range(0, 3)), 30, 15, 15);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
